FILE: sv/dtpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtpw_pkg;

   // Screen size in pixels; the store holds one entry per pixel.
   localparam int SCREEN_COLUMNS = 256;
   localparam int SCREEN_ROWS    = 256;

   localparam int STORE_AW      = 16;
   localparam int STORE_ENTRIES = 1 << STORE_AW;

   localparam logic [31:0] DEPTH_FAR = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      ACT_PLOT  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      ST_IDLE  = 1'b0,
      ST_SWEEP = 1'b1
   } state_type;

endpackage

`default_nettype wire

FILE: sv/depth_tested_pixel_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Depth-tested pixel writer. A color memory and a depth memory hold one 32-bit
// entry per screen pixel, each with one synchronous read port and one write
// port. Plot and read items flow through a two-step read-modify-write path:
// the memories are read in the cycle the item is accepted, and the depth test
// and write-back happen when the item leaves the second step, as its result is
// loaded into the output register; the item waits there while that register
// holds a result not yet taken. A new plot or read item is accepted every
// cycle while results are taken, so the rate is one item per cycle; a write to
// the pixel just read is forwarded to the following item. A clear item returns
// its all-zero result at once and then sweeps both memories, one entry per
// cycle; no item is accepted during the sweep. The memories hold no defined
// contents after reset, so a clear must come before the first plot or read.
module depth_tested_pixel_writer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [15:0] req_pixel_x,
   input  wire logic signed [15:0] req_pixel_y,
   input  wire logic signed [31:0] req_pixel_depth,
   input  wire logic [31:0]        req_pixel_color,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic               rsp_written,
   output      logic               rsp_in_bounds,
   output      logic [31:0]        rsp_stored_color,
   output      logic signed [31:0] rsp_stored_depth
);

   localparam int AW = dtpw_pkg::STORE_AW;

   // Memories.
   logic [31:0] color_store_ff [dtpw_pkg::STORE_ENTRIES];
   logic [31:0] depth_store_ff [dtpw_pkg::STORE_ENTRIES];
   logic [31:0] color_rd_ff;
   logic [31:0] depth_rd_ff;

   // Sweep control.
   dtpw_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_ptr_ff, clr_ptr_in;
   logic                sweeping;

   // Second step of the item path.
   logic                 s1_valid_ff, s1_valid_in;
   dtpw_pkg::action_type s1_action_ff;
   logic                 s1_ok_ff;
   logic [AW-1:0]        s1_addr_ff;
   logic signed [31:0]   s1_depth_ff;
   logic [31:0]          s1_color_ff;
   logic                 s1_fwd_ff, s1_fwd_in;
   logic [31:0]          s1_fwd_color_ff;
   logic [31:0]          s1_fwd_depth_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_written_ff, rsp_written_in;
   logic               rsp_in_bounds_ff, rsp_in_bounds_in;
   logic [31:0]        rsp_color_ff, rsp_color_in;
   logic signed [31:0] rsp_depth_ff, rsp_depth_in;

   // Combinational.
   logic          x_ok, y_ok, req_ok;
   logic [31:0]   row_base;
   logic [AW-1:0] req_addr;
   logic          accept;
   logic          s1_adv;
   logic [31:0]   old_color, old_depth;
   logic          depth_pass;
   logic          plot_we;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wcolor, mem_wdepth;

   // Bounds check per coordinate; negative values are off the screen.
   assign x_ok = !req_pixel_x[15] &&
                 ($unsigned(req_pixel_x) < 16'(dtpw_pkg::SCREEN_COLUMNS));
   assign y_ok = !req_pixel_y[15] &&
                 ($unsigned(req_pixel_y) < 16'(dtpw_pkg::SCREEN_ROWS));
   assign req_ok = x_ok && y_ok;

   assign row_base = 32'($unsigned(req_pixel_y)) * 32'(dtpw_pkg::SCREEN_COLUMNS);
   assign req_addr = row_base[AW-1:0] + AW'($unsigned(req_pixel_x));

   // Sweep state machine.
   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = '0;
      sweeping   = 1'b0;
      case (state_ff)
         dtpw_pkg::ST_IDLE: begin
            if (s1_adv && s1_action_ff == dtpw_pkg::ACT_CLEAR) begin
               state_in = dtpw_pkg::ST_SWEEP;
            end
         end
         dtpw_pkg::ST_SWEEP: begin
            sweeping   = 1'b1;
            clr_ptr_in = clr_ptr_ff + AW'(1);
            if (clr_ptr_ff == {AW{1'b1}}) begin
               state_in = dtpw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtpw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dtpw_pkg::ST_IDLE;
         clr_ptr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   // Item path.
   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   // A clear in the second step holds off new items until its sweep is done.
   assign req_ready = (state_ff == dtpw_pkg::ST_IDLE) &&
                      (!s1_valid_ff ||
                       (s1_adv && s1_action_ff != dtpw_pkg::ACT_CLEAR));
   assign accept = req_valid && req_ready;

   assign old_color  = s1_fwd_ff ? s1_fwd_color_ff : color_rd_ff;
   assign old_depth  = s1_fwd_ff ? s1_fwd_depth_ff : depth_rd_ff;
   // A stored depth of exactly zero always lets the new pixel through.
   assign depth_pass = (old_depth == 32'd0) || ($signed(old_depth) > s1_depth_ff);
   assign plot_we    = s1_adv && s1_ok_ff && depth_pass &&
                       (s1_action_ff == dtpw_pkg::ACT_PLOT);

   assign mem_we     = sweeping || plot_we;
   assign mem_waddr  = sweeping ? clr_ptr_ff : s1_addr_ff;
   assign mem_wcolor = sweeping ? 32'd0 : s1_color_ff;
   assign mem_wdepth = sweeping ? dtpw_pkg::DEPTH_FAR : $unsigned(s1_depth_ff);

   // The memory returns the old entry when it is written in the cycle it is
   // read, so the write of the item ahead is captured for the new item.
   assign s1_fwd_in = plot_we && (s1_addr_ff == req_addr);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         color_store_ff[mem_waddr] <= mem_wcolor;
         depth_store_ff[mem_waddr] <= mem_wdepth;
      end
      if (accept) begin
         color_rd_ff <= color_store_ff[req_addr];
         depth_rd_ff <= depth_store_ff[req_addr];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff    <= dtpw_pkg::action_type'(req_action);
         s1_ok_ff        <= req_ok;
         s1_addr_ff      <= req_addr;
         s1_depth_ff     <= req_pixel_depth;
         s1_color_ff     <= req_pixel_color;
         s1_fwd_ff       <= s1_fwd_in;
         s1_fwd_color_ff <= s1_color_ff;
         s1_fwd_depth_ff <= $unsigned(s1_depth_ff);
      end
   end

   // Result of the item in the second step.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_written_in   = rsp_written_ff;
      rsp_in_bounds_in = rsp_in_bounds_ff;
      rsp_color_in     = rsp_color_ff;
      rsp_depth_in     = rsp_depth_ff;
      if (s1_adv) begin
         rsp_valid_in     = 1'b1;
         rsp_written_in   = 1'b0;
         rsp_in_bounds_in = 1'b0;
         rsp_color_in     = 32'd0;
         rsp_depth_in     = 32'sd0;
         case (s1_action_ff)
            dtpw_pkg::ACT_PLOT: begin
               if (s1_ok_ff) begin
                  rsp_written_in   = depth_pass;
                  rsp_in_bounds_in = 1'b1;
                  rsp_color_in     = depth_pass ? s1_color_ff : old_color;
                  rsp_depth_in     = depth_pass ? s1_depth_ff : $signed(old_depth);
               end
            end
            dtpw_pkg::ACT_READ: begin
               if (s1_ok_ff) begin
                  rsp_in_bounds_in = 1'b1;
                  rsp_color_in     = old_color;
                  rsp_depth_in     = $signed(old_depth);
               end
            end
            default: begin
               rsp_written_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_written_ff   <= rsp_written_in;
      rsp_in_bounds_ff <= rsp_in_bounds_in;
      rsp_color_ff     <= rsp_color_in;
      rsp_depth_ff     <= rsp_depth_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_written      = rsp_written_ff;
   assign rsp_in_bounds    = rsp_in_bounds_ff;
   assign rsp_stored_color = rsp_color_ff;
   assign rsp_stored_depth = rsp_depth_ff;

   // Checks.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dtpw_pkg::ST_SWEEP) |-> !req_ready)
      else $error("item accepted during clear sweep");

   a_no_item_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dtpw_pkg::ST_SWEEP) |-> !s1_valid_ff)
      else $error("item in flight during clear sweep");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dtpw_pkg::ST_SWEEP && clr_ptr_ff == {AW{1'b1}})
      |=> (state_ff == dtpw_pkg::ST_IDLE))
      else $error("clear sweep did not end at last entry");

   a_written_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_written_ff) |-> rsp_in_bounds_ff)
      else $error("write reported for off-screen pixel");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int OUTPUT_HOLD_CYCLES = 500;
   localparam int RANDOM_ITEMS       = 840;

   typedef struct packed {
      logic               written;
      logic               in_bounds;
      logic [31:0]        color;
      logic signed [31:0] depth;
   } pixel_result_type;

   // Mirrors both frame stores and queues the result that each accepted item must produce.
   class depth_test_scoreboard;
      logic [31:0]        frame_color [dtpw_pkg::STORE_ENTRIES];
      logic signed [31:0] frame_depth [dtpw_pkg::STORE_ENTRIES];
      pixel_result_type   pending_pixels [$];
      int                 mismatches;
      int                 results_checked;
      int                 writes_expected;
      int                 clears_seen;

      function void apply_action(dtpw_pkg::action_type act, logic signed [15:0] x,
                                 logic signed [15:0] y, logic signed [31:0] depth,
                                 logic [31:0] color);
         pixel_result_type res;
         int               idx;
         logic             on_screen;
         res = '0;
         on_screen = (x >= 0) && (x < dtpw_pkg::SCREEN_COLUMNS) &&
                     (y >= 0) && (y < dtpw_pkg::SCREEN_ROWS);
         idx = (int'(y) * dtpw_pkg::SCREEN_COLUMNS + int'(x)) % dtpw_pkg::STORE_ENTRIES;
         if (act == dtpw_pkg::ACT_CLEAR) begin
            foreach (frame_color[i]) begin
               frame_color[i] = '0;
               frame_depth[i] = dtpw_pkg::DEPTH_FAR;
            end
            clears_seen++;
         end else if ((act == dtpw_pkg::ACT_PLOT || act == dtpw_pkg::ACT_READ) &&
                      on_screen) begin
            // A stored depth of exactly zero never blocks a plot.
            if (act == dtpw_pkg::ACT_PLOT &&
                (frame_depth[idx] == 0 || frame_depth[idx] > depth)) begin
               frame_depth[idx] = depth;
               frame_color[idx] = color;
               res.written = 1'b1;
               writes_expected++;
            end
            res.in_bounds = 1'b1;
            res.color     = frame_color[idx];
            res.depth     = frame_depth[idx];
         end
         pending_pixels.push_back(res);
      endfunction

      task report(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         $display("MISMATCH at result %0d, %s: expected %h, got %h",
                  results_checked, what, want, got);
      endtask

      task compare_pixel_result(pixel_result_type got);
         pixel_result_type want;
         if (pending_pixels.size() == 0) begin
            report("result with none pending (color)", '0, got.color);
         end else begin
            want = pending_pixels.pop_front();
            results_checked++;
            if (got.written !== want.written)
               report("written", 32'(want.written), 32'(got.written));
            if (got.in_bounds !== want.in_bounds)
               report("in_bounds", 32'(want.in_bounds), 32'(got.in_bounds));
            if (got.color !== want.color)
               report("stored_color", want.color, got.color);
            if (got.depth !== want.depth)
               report("stored_depth", want.depth, got.depth);
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = dtpw_pkg::ACT_NONE;
   logic signed [15:0] req_pixel_x = '0;
   logic signed [15:0] req_pixel_y = '0;
   logic signed [31:0] req_pixel_depth = '0;
   logic [31:0]        req_pixel_color = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_written;
   logic               rsp_in_bounds;
   logic [31:0]        rsp_stored_color;
   logic signed [31:0] rsp_stored_depth;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int clears_left  = 3;
   int items_offered = 0;
   bit hold_pending = 1'b0;

   depth_test_scoreboard scoreboard = new;

   depth_tested_pixel_writer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_pixel_depth  (req_pixel_depth),
      .req_pixel_color  (req_pixel_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_written      (rsp_written),
      .rsp_in_bounds    (rsp_in_bounds),
      .rsp_stored_color (rsp_stored_color),
      .rsp_stored_depth (rsp_stored_depth)
   );

   always #5 clock = ~clock;

   // Inputs are noted before results are checked so that either latency is handled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            scoreboard.apply_action(dtpw_pkg::action_type'(req_action), req_pixel_x,
                                    req_pixel_y, req_pixel_depth, req_pixel_color);
         if (rsp_valid && rsp_ready)
            scoreboard.compare_pixel_result({rsp_written, rsp_in_bounds,
                                             rsp_stored_color, rsp_stored_depth});
      end
   end

   initial begin : result_taker
      int k;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (k = 0; k < OUTPUT_HOLD_CYCLES; k++)
               @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         @(posedge clock);
      end
   end

   task automatic offer_pixel(dtpw_pkg::action_type act, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [31:0] depth,
                              logic [31:0] color);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_pixel_x     <= x;
      req_pixel_y     <= y;
      req_pixel_depth <= depth;
      req_pixel_color <= color;
      items_offered++;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Most items hit a small hot corner so that depth tests and back-to-back
   // updates of the same pixel happen often.
   task automatic offer_random_pixel();
      dtpw_pkg::action_type act;
      logic signed [15:0]   x;
      logic signed [15:0]   y;
      logic signed [31:0]   depth;
      int                   pick;
      pick = $urandom_range(999);
      if (pick < 4 && clears_left > 0) begin
         act = dtpw_pkg::ACT_CLEAR;
         clears_left--;
      end else if (pick < 600) begin
         act = dtpw_pkg::ACT_PLOT;
      end else if (pick < 950) begin
         act = dtpw_pkg::ACT_READ;
      end else begin
         act = dtpw_pkg::ACT_NONE;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
         x = 16'($urandom_range(7));
         y = 16'($urandom_range(7));
      end else if (pick < 80) begin
         x = 16'($urandom_range(dtpw_pkg::SCREEN_COLUMNS - 1));
         y = 16'($urandom_range(dtpw_pkg::SCREEN_ROWS - 1));
      end else if (pick < 90) begin
         x = 16'($urandom_range(dtpw_pkg::SCREEN_COLUMNS + 1) - 1);
         y = 16'($urandom_range(dtpw_pkg::SCREEN_ROWS + 1) - 1);
      end else begin
         x = 16'($urandom);
         y = 16'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 45)
         depth = $urandom_range(15);
      else if (pick < 60)
         depth = $urandom_range(15) - 8;
      else if (pick < 70)
         depth = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else
         depth = $urandom;
      offer_pixel(act, x, y, depth, $urandom);
   endtask

   initial begin : stimulus
      int phase;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      offer_pixel(dtpw_pkg::ACT_CLEAR, 0, 0, 0, 32'h0);
      offer_pixel(dtpw_pkg::ACT_READ, 0, 0, 0, 32'h0);
      offer_pixel(dtpw_pkg::ACT_PLOT, 0, 0, 100, 32'h1111_1111);
      offer_pixel(dtpw_pkg::ACT_PLOT, 0, 0, 100, 32'h2222_2222);
      offer_pixel(dtpw_pkg::ACT_PLOT, 0, 0, 99, 32'h3333_3333);
      offer_pixel(dtpw_pkg::ACT_PLOT, 255, 255, 32'sh8000_0000, 32'hFFFF_FFFF);
      offer_pixel(dtpw_pkg::ACT_PLOT, 255, 255, 32'sh7FFF_FFFF, 32'h4444_4444);
      offer_pixel(dtpw_pkg::ACT_PLOT, 256, 0, -5, 32'h5555_5555);
      offer_pixel(dtpw_pkg::ACT_PLOT, 0, 256, -5, 32'h5555_5555);
      offer_pixel(dtpw_pkg::ACT_PLOT, -1, 5, -5, 32'h5555_5555);
      offer_pixel(dtpw_pkg::ACT_PLOT, 16'sh8000, 16'sh7FFF, -5, 32'h5555_5555);
      offer_pixel(dtpw_pkg::ACT_READ, 16'sh7FFF, 16'sh8000, 0, 32'h0);
      // A zero depth is stored, after which any depth overwrites it.
      offer_pixel(dtpw_pkg::ACT_PLOT, 10, 10, 0, 32'hAAAA_5555);
      offer_pixel(dtpw_pkg::ACT_PLOT, 10, 10, 32'sh7FFF_FFFF, 32'h5555_AAAA);
      offer_pixel(dtpw_pkg::ACT_PLOT, 10, 10, 32'sh7FFF_FFFF, 32'h0F0F_0F0F);
      // The last column of a row and the first of the next must not alias.
      offer_pixel(dtpw_pkg::ACT_PLOT, 255, 0, 5, 32'h0000_00FF);
      offer_pixel(dtpw_pkg::ACT_PLOT, 0, 1, 5, 32'h0000_FF00);
      offer_pixel(dtpw_pkg::ACT_READ, 255, 0, 0, 32'h0);
      offer_pixel(dtpw_pkg::ACT_READ, 0, 1, 0, 32'h0);
      offer_pixel(dtpw_pkg::ACT_NONE, 3, 3, -1, 32'hDEAD_BEEF);
      offer_pixel(dtpw_pkg::ACT_READ, 255, 255, 0, 32'h0);
      offer_pixel(dtpw_pkg::ACT_CLEAR, 7, 7, 7, 32'h7);
      offer_pixel(dtpw_pkg::ACT_READ, 0, 0, 0, 32'h0);
      offer_pixel(dtpw_pkg::ACT_PLOT, 3, 3, 1, 32'h0);

      for (phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 70 : 0;
         rsp_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 25 : 0;
         for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
            if (phase == 2 && n == 60)
               hold_pending = 1'b1;
            offer_random_pixel();
         end
      end
      req_valid <= 1'b0;

      while (scoreboard.pending_pixels.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Ran %0d items, %0d of them clears, and checked %0d results.",
               items_offered, scoreboard.clears_seen, scoreboard.results_checked);
      $display("%0d plots won the depth test, under idling on either side, %s",
               scoreboard.writes_expected, "none, and a long output stall.");
      if (scoreboard.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("Timed out with %0d results still pending.", scoreboard.pending_pixels.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
